// ----- sv/rri_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types and constants of the ray / bounded plane intersection core.
// ----------------------------------------------------------------------------
package rri_pkg;

   // Miss cause codes.
   localparam logic [2:0] CAUSE_HIT      = 3'd0;
   localparam logic [2:0] CAUSE_PARALLEL = 3'd1;
   localparam logic [2:0] CAUSE_RANGE    = 3'd2;
   localparam logic [2:0] CAUSE_OUT_U    = 3'd3;
   localparam logic [2:0] CAUSE_OUT_V    = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] REG_NORMAL   = 3'd0;
   localparam logic [2:0] REG_AXIS_U   = 3'd1;
   localparam logic [2:0] REG_AXIS_V   = 3'd2;
   localparam logic [2:0] REG_CENTER   = 3'd3;
   localparam logic [2:0] REG_OFFSET   = 3'd4;
   localparam logic [2:0] REG_HALF_U   = 3'd5;
   localparam logic [2:0] REG_HALF_V   = 3'd6;

   localparam logic [15:0] UNBOUNDED = 16'hFFFF;

   // Classified ray handed from the front end to the back end.
   typedef struct packed {
      logic             parallel;
      logic             neg;        // quotient sign is negative
      logic [47:0]      num_mag;    // |numerator| * 2^14
      logic [32:0]      den_mag;    // |denominator|
      logic [2:0][15:0] org;
      logic [2:0][15:0] dir;
      logic [15:0]      maxd;
   } job_type;

   // One stage of the division pipeline.
   typedef struct packed {
      logic             parallel;
      logic             miss;
      logic [47:0]      rem;
      logic [32:0]      dvs;
      logic [15:0]      quo;
      logic [2:0][15:0] org;
      logic [2:0][15:0] dir;
      logic [15:0]      maxd;
   } div_type;

endpackage
`default_nettype wire

// ----- sv/rri_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rri_front
// Accepts rays, forms the plane dot products and classifies each ray.
// ----------------------------------------------------------------------------
module rri_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [2:0][15:0]   in_org,
   input  wire logic [2:0][15:0]   in_dir,
   input  wire logic [15:0]        in_maxd,
   input  wire logic [47:0]        normal_vec,
   input  wire logic [15:0]        plane_offset,
   input  wire logic               en,
   output logic                    push,
   output rri_pkg::job_type        job
);

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [31:0]      pdn_ff [3];
   logic signed [31:0]      pon_ff [3];
   logic [2:0][15:0]        org1_ff, dir1_ff, org2_ff, dir2_ff;
   logic [15:0]             maxd1_ff, maxd2_ff, po1_ff;
   logic signed [34:0]      den_ff, num_ff;
   logic signed [34:0]      den_in, num_in;
   rri_pkg::job_type        job_ff, job_in;

   // Valid bits advance with the front enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage one: the six products with the normal.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pdn_ff[i] <= $signed(in_dir[i]) * $signed(normal_vec[16*i +: 16]);
            pon_ff[i] <= $signed(in_org[i]) * $signed(normal_vec[16*i +: 16]);
         end
         org1_ff  <= in_org;
         dir1_ff  <= in_dir;
         maxd1_ff <= in_maxd;
         po1_ff   <= plane_offset;
      end
   end

   // Stage two: denominator and numerator sums.
   always_comb begin
      den_in = 35'(pdn_ff[0]) + 35'(pdn_ff[1]) + 35'(pdn_ff[2]);
      num_in = (35'($signed(po1_ff)) <<< 14)
               - (35'(pon_ff[0]) + 35'(pon_ff[1]) + 35'(pon_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff   <= den_in;
         num_ff   <= num_in;
         org2_ff  <= org1_ff;
         dir2_ff  <= dir1_ff;
         maxd2_ff <= maxd1_ff;
      end
   end

   // Stage three: classify and take magnitudes for the divider.
   always_comb begin
      logic [34:0] nm;
      logic [34:0] dm;
      nm = num_ff[34] ? 35'(-num_ff) : 35'(num_ff);
      dm = den_ff[34] ? 35'(-den_ff) : 35'(den_ff);
      job_in.parallel = (den_ff == '0);
      job_in.neg      = num_ff[34] ^ den_ff[34];
      job_in.num_mag  = {nm[33:0], 14'b0};
      job_in.den_mag  = dm[32:0];
      job_in.org      = org2_ff;
      job_in.dir      = dir2_ff;
      job_in.maxd     = maxd2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         job_ff <= job_in;
      end
   end

   assign push = v3_ff & en;
   assign job  = job_ff;

endmodule
`default_nettype wire

// ----- sv/rri_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rri_queue
// Four-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rri_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rri_pkg::job_type   wr_job,
   input  wire logic               pop,
   output rri_pkg::job_type        rd_job,
   output logic                    empty,
   output logic                    full
);

   rri_pkg::job_type mem [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= wr_job;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end

   assign rd_job = mem[rp_ff];
   assign empty  = (cnt_ff == 3'd0);
   assign full   = (cnt_ff == 3'd4);

endmodule
`default_nettype wire

// ----- sv/rri_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rri_back
// Divides for the hit distance, forms the hit point and checks the bounds.
// ----------------------------------------------------------------------------
module rri_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire rri_pkg::job_type   job,
   input  wire logic               en,
   input  wire logic [47:0]        axis_u_vec,
   input  wire logic [47:0]        axis_v_vec,
   input  wire logic [47:0]        center_vec,
   input  wire logic [15:0]        half_extent_u,
   input  wire logic [15:0]        half_extent_v,
   output logic                    out_valid,
   output logic                    hit,
   output logic [2:0]              miss_cause,
   output logic [15:0]             hit_dist,
   output logic [2:0][15:0]        hit_pt
);

   localparam int QW = 16;

   logic                    dv_ff [QW+1];
   rri_pkg::div_type        div_ff [QW+1];
   rri_pkg::div_type        div_in [QW+1];
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;
   logic                    par1_ff, par2_ff, par3_ff, par4_ff, par5_ff;
   logic                    miss1_ff, miss2_ff, miss3_ff, miss4_ff, miss5_ff;
   logic [15:0]             t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic [2:0][15:0]        org1_ff, dir1_ff, org2_ff;
   logic signed [31:0]      prod_ff [3];
   logic signed [18:0]      pt_ff [3];
   logic signed [18:0]      pt4_ff [3];
   logic signed [18:0]      pt5_ff [3];
   logic signed [19:0]      d_ff [3];
   logic signed [35:0]      pu_ff [3];
   logic signed [35:0]      pv_ff [3];
   logic signed [37:0]      su_ff, sv_ff;
   logic                    hit_ff;
   logic [2:0]              cause_ff;
   logic [15:0]             dist_ff;
   logic [2:0][15:0]        pto_ff;

   // Valid bits through the whole back pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) dv_ff[i] <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= in_valid;
         for (int i = 1; i <= QW; i++) dv_ff[i] <= dv_ff[i-1];
         v1_ff <= dv_ff[QW];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vo_ff <= v5_ff;
      end
   end

   // Entry stage: a parallel ray, a negative quotient or a quotient of 2^16 or more is a miss at once.
   always_comb begin
      div_in[0].parallel = job.parallel;
      div_in[0].miss     = job.parallel | job.neg
                           | ({1'b0, job.num_mag} >= {job.den_mag, 16'b0});
      div_in[0].rem      = job.num_mag;
      div_in[0].dvs      = job.den_mag;
      div_in[0].quo      = '0;
      div_in[0].org      = job.org;
      div_in[0].dir      = job.dir;
      div_in[0].maxd     = job.maxd;
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 1; k <= QW; k++) begin : g_div
      always_comb begin
         logic [48:0] sh;
         sh = 49'(div_ff[k-1].dvs) << (QW - k);
         div_in[k] = div_ff[k-1];
         if ({1'b0, div_ff[k-1].rem} >= sh) begin
            div_in[k].rem          = div_ff[k-1].rem - sh[47:0];
            div_in[k].quo[QW - k]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= QW; i++) div_ff[i] <= div_in[i];
      end
   end

   // Range check on the truncated distance.
   always_ff @(posedge clock) begin
      if (en) begin
         par1_ff  <= div_ff[QW].parallel;
         miss1_ff <= div_ff[QW].miss | (div_ff[QW].quo == '0)
                     | (div_ff[QW].quo > div_ff[QW].maxd);
         t1_ff    <= div_ff[QW].quo;
         org1_ff  <= div_ff[QW].org;
         dir1_ff  <= div_ff[QW].dir;
      end
   end

   // Distance times direction.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= 32'($signed({1'b0, t1_ff}) * $signed(dir1_ff[i]));
         end
         par2_ff  <= par1_ff;
         miss2_ff <= miss1_ff;
         t2_ff    <= t1_ff;
         org2_ff  <= org1_ff;
      end
   end

   // Hit point (floor of the scaled product) and offset from the center.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pt_ff[i] <= 19'($signed(org2_ff[i])) + 19'(prod_ff[i] >>> 14);
            d_ff[i]  <= 20'($signed(org2_ff[i])) + 20'(prod_ff[i] >>> 14)
                        - 20'($signed(center_vec[16*i +: 16]));
         end
         par3_ff  <= par2_ff;
         miss3_ff <= miss2_ff;
         t3_ff    <= t2_ff;
      end
   end

   // Projections onto both in-plane axes.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pu_ff[i]  <= d_ff[i] * $signed(axis_u_vec[16*i +: 16]);
            pv_ff[i]  <= d_ff[i] * $signed(axis_v_vec[16*i +: 16]);
            pt4_ff[i] <= pt_ff[i];
         end
         par4_ff  <= par3_ff;
         miss4_ff <= miss3_ff;
         t4_ff    <= t3_ff;
      end
   end

   // Projection sums.
   always_ff @(posedge clock) begin
      if (en) begin
         su_ff <= 38'(pu_ff[0]) + 38'(pu_ff[1]) + 38'(pu_ff[2]);
         sv_ff <= 38'(pv_ff[0]) + 38'(pv_ff[1]) + 38'(pv_ff[2]);
         for (int i = 0; i < 3; i++) pt5_ff[i] <= pt4_ff[i];
         par5_ff  <= par4_ff;
         miss5_ff <= miss4_ff;
         t5_ff    <= t4_ff;
      end
   end

   // Bounds test and result assembly.
   always_ff @(posedge clock) begin
      logic [37:0] au;
      logic [37:0] av;
      logic        out_u;
      logic        out_v;
      if (en) begin
         au    = su_ff[37] ? 38'(-su_ff) : 38'(su_ff);
         av    = sv_ff[37] ? 38'(-sv_ff) : 38'(sv_ff);
         out_u = (half_extent_u != rri_pkg::UNBOUNDED) && (au > {8'b0, half_extent_u, 14'b0});
         out_v = (half_extent_v != rri_pkg::UNBOUNDED) && (av > {8'b0, half_extent_v, 14'b0});
         hit_ff  <= 1'b0;
         dist_ff <= '0;
         pto_ff  <= '0;
         if (par5_ff) begin
            cause_ff <= rri_pkg::CAUSE_PARALLEL;
         end else if (miss5_ff) begin
            cause_ff <= rri_pkg::CAUSE_RANGE;
         end else if (out_u) begin
            cause_ff <= rri_pkg::CAUSE_OUT_U;
         end else if (out_v) begin
            cause_ff <= rri_pkg::CAUSE_OUT_V;
         end else begin
            cause_ff <= rri_pkg::CAUSE_HIT;
            hit_ff   <= 1'b1;
            dist_ff  <= t5_ff;
            for (int i = 0; i < 3; i++) begin
               if (pt5_ff[i] > 19'sd32767) begin
                  pto_ff[i] <= 16'h7FFF;
               end else if (pt5_ff[i] < -19'sd32768) begin
                  pto_ff[i] <= 16'h8000;
               end else begin
                  pto_ff[i] <= pt5_ff[i][15:0];
               end
            end
         end
      end
   end

   assign out_valid  = vo_ff;
   assign hit        = hit_ff;
   assign miss_cause = cause_ff;
   assign hit_dist   = dist_ff;
   assign hit_pt     = pto_ff;

endmodule
`default_nettype wire

// ----- sv/ray_rectangle_intersect_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_rectangle_intersect_core
// Intersects a stream of rays with a plane that may be bounded to a rectangle.
// ----------------------------------------------------------------------------
// The core takes one ray per clock cycle while req_ready is high and returns
// one result per ray, in order. A ray passes through the front end (dot
// products, sums, classification), a four-entry queue and the back end, whose
// 23 register stages are mostly the 16-stage restoring divider that produces
// the distance one quotient bit per stage. A held result stalls the back end;
// the front end keeps accepting rays until the queue is full.
// Configuration registers are read live, so write them only while no ray is
// in flight.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_origin_x,
   input  wire logic signed [15:0] req_origin_y,
   input  wire logic signed [15:0] req_origin_z,
   input  wire logic signed [15:0] req_dir_x,
   input  wire logic signed [15:0] req_dir_y,
   input  wire logic signed [15:0] req_dir_z,
   input  wire logic [15:0]        req_max_dist,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_hit,
   output logic [2:0]              rsp_miss_cause,
   output logic [15:0]             rsp_hit_dist,
   output logic signed [15:0]      rsp_hit_x,
   output logic signed [15:0]      rsp_hit_y,
   output logic signed [15:0]      rsp_hit_z,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [47:0]        csr_wdata
);

   logic [47:0]      normal_ff, axis_u_ff, axis_v_ff, center_ff;
   logic [15:0]      offset_ff, half_u_ff, half_v_ff;
   logic             front_en, back_en, push, pop, q_empty, q_full;
   rri_pkg::job_type wr_job, rd_job;
   logic [2:0][15:0] hit_pt;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff <= 48'h4000_0000_0000;
         axis_u_ff <= 48'h0000_0000_4000;
         axis_v_ff <= 48'h0000_4000_0000;
         center_ff <= '0;
         offset_ff <= '0;
         half_u_ff <= rri_pkg::UNBOUNDED;
         half_v_ff <= rri_pkg::UNBOUNDED;
      end else if (csr_we) begin
         unique case (csr_index)
            rri_pkg::REG_NORMAL: normal_ff <= csr_wdata;
            rri_pkg::REG_AXIS_U: axis_u_ff <= csr_wdata;
            rri_pkg::REG_AXIS_V: axis_v_ff <= csr_wdata;
            rri_pkg::REG_CENTER: center_ff <= csr_wdata;
            rri_pkg::REG_OFFSET: offset_ff <= csr_wdata[15:0];
            rri_pkg::REG_HALF_U: half_u_ff <= csr_wdata[15:0];
            rri_pkg::REG_HALF_V: half_v_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Flow control: the back end stalls on the result, the front end on the queue.
   assign back_en   = !rsp_valid || rsp_ready;
   assign pop       = !q_empty && back_en;
   assign front_en  = !q_full || pop;
   assign req_ready = front_en;

   rri_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_org       ({req_origin_z, req_origin_y, req_origin_x}),
      .in_dir       ({req_dir_z, req_dir_y, req_dir_x}),
      .in_maxd      (req_max_dist),
      .normal_vec   (normal_ff),
      .plane_offset (offset_ff),
      .en           (front_en),
      .push         (push),
      .job          (wr_job)
   );

   rri_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (wr_job),
      .pop    (pop),
      .rd_job (rd_job),
      .empty  (q_empty),
      .full   (q_full)
   );

   rri_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pop),
      .job           (rd_job),
      .en            (back_en),
      .axis_u_vec    (axis_u_ff),
      .axis_v_vec    (axis_v_ff),
      .center_vec    (center_ff),
      .half_extent_u (half_u_ff),
      .half_extent_v (half_v_ff),
      .out_valid     (rsp_valid),
      .hit           (rsp_hit),
      .miss_cause    (rsp_miss_cause),
      .hit_dist      (rsp_hit_dist),
      .hit_pt        (hit_pt)
   );

   assign rsp_hit_x = hit_pt[0];
   assign rsp_hit_y = hit_pt[1];
   assign rsp_hit_z = hit_pt[2];

endmodule
`default_nettype wire
